// ===== rtl/pmcd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PBCH MIB check package
// Shared widths, antenna codes, decoded field type and CRC-16 constants.
// ----------------------------------------------------------------------------
package pmcd_pkg;

	localparam int INFO_W = 24;
	localparam int CRC_W = 16;
	localparam int SFN_W = 10;
	localparam int BW_W = 3;
	localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;
	localparam logic [BW_W-1:0] BW_MAX = 3'd5;
	localparam logic [BW_W-1:0] BW_UNKNOWN = 3'd6;
	localparam logic [CRC_W-1:0] MASK_ONE = 16'h0000;
	localparam logic [CRC_W-1:0] MASK_TWO = 16'hFFFF;
	localparam logic [CRC_W-1:0] MASK_FOUR = 16'h5555;

	typedef enum logic [1:0] {
		ANT_ONE   = 2'd0,
		ANT_TWO   = 2'd1,
		ANT_FOUR  = 2'd2,
		ANT_UNSUP = 2'd3
	} ant_code_t;

	typedef struct packed {
		logic [BW_W-1:0]  bandwidth_code;
		logic             phich_duration;
		logic [1:0]       phich_resource;
		logic [SFN_W-1:0] frame_number;
	} mib_fields_t;

	// The CRC is linear in the information bits, so each bit contributes a
	// fixed 16-bit column; these columns are evaluated at elaboration.
	function automatic logic [INFO_W-1:0][CRC_W-1:0] crc_cols_f();
		logic [INFO_W-1:0][CRC_W-1:0] cols;
		logic [CRC_W-1:0] crc;
		logic fb;
		for (int b = 0; b < INFO_W; b++) begin
			crc = '0;
			for (int i = INFO_W - 1; i >= 0; i--) begin
				fb = crc[CRC_W-1] ^ (i == b);
				crc = {crc[CRC_W-2:0], 1'b0};
				if (fb) begin
					crc = crc ^ CRC_POLY;
				end
			end
			cols[b] = crc;
		end
		return cols;
	endfunction

endpackage

// ===== rtl/pmcd_crc_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PBCH MIB CRC check
// Unmasks the received CRC by antenna hypothesis and compares it with the
// CRC-16 of the information bits.
// ----------------------------------------------------------------------------
module pmcd_crc_check
	import pmcd_pkg::*;
(
	input  logic [INFO_W-1:0] info_bits,
	input  logic [CRC_W-1:0]  crc_bits,
	input  logic [1:0]        antenna_code,
	output logic              crc_ok
);

	localparam logic [INFO_W-1:0][CRC_W-1:0] CRC_COLS = crc_cols_f();

	logic [CRC_W-1:0] crc_calc;
	logic [CRC_W-1:0] mask;
	logic             mask_valid;

	always_comb begin
		crc_calc = '0;
		for (int i = 0; i < INFO_W; i++) begin
			if (info_bits[i]) begin
				crc_calc = crc_calc ^ CRC_COLS[i];
			end
		end
	end

	always_comb begin
		mask = MASK_ONE;
		mask_valid = 1'b1;
		case (ant_code_t'(antenna_code))
			ANT_ONE: begin
				mask = MASK_ONE;
			end
			ANT_TWO: begin
				mask = MASK_TWO;
			end
			ANT_FOUR: begin
				mask = MASK_FOUR;
			end
			default: begin
				mask_valid = 1'b0;
			end
		endcase
	end

	assign crc_ok = mask_valid && ((crc_bits ^ mask) == crc_calc);

endmodule

// ===== rtl/pmcd_mib_fields.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PBCH MIB field decode
// Extracts bandwidth, PHICH configuration and system frame number.
// ----------------------------------------------------------------------------
module pmcd_mib_fields
	import pmcd_pkg::*;
(
	input  logic [INFO_W-1:0] info_bits,
	input  logic [1:0]        frame_hypothesis,
	input  logic [1:0]        frame_index,
	output mib_fields_t       fields
);

	logic [BW_W-1:0] bw_raw;

	assign bw_raw = info_bits[23:21];

	always_comb begin
		fields.bandwidth_code = (bw_raw > BW_MAX) ? BW_UNKNOWN : bw_raw;
		fields.phich_duration = info_bits[20];
		fields.phich_resource = info_bits[19:18];
		fields.frame_number = {info_bits[17:10], 2'b00}
			+ {{(SFN_W-2){1'b0}}, frame_hypothesis}
			- {{(SFN_W-2){1'b0}}, frame_index};
	end

endmodule

// ===== rtl/pbch_mib_crc_check_decode_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PBCH MIB CRC check and decode
// Checks the masked CRC-16 of one broadcast word and decodes its fields.
// ----------------------------------------------------------------------------
// Usage:
// A word is presented on info_bits, crc_bits, antenna_code, frame_hypothesis
// and frame_index and is taken at a rising edge where start is high and busy
// is low. Busy stays low, so a new word can be given in every cycle.
// The word is registered at the input, checked and decoded in one pass of
// logic, and the result is registered at the output. The result appears on
// crc_ok, bandwidth_code, phich_duration, phich_resource, frame_number and
// antenna_ports with done high for exactly one cycle, after the word has passed
// through the input register and then the result register.
// Throughput is one word per cycle.
// The receiver cannot stall; every result must be taken in its done cycle.
// Reset clears the valid flags of both stages, so no result is reported
// for words in flight at reset.
// ----------------------------------------------------------------------------
module pbch_mib_crc_check_decode_top
	import pmcd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [INFO_W-1:0] info_bits,
	input  logic [CRC_W-1:0]  crc_bits,
	input  logic [1:0]        antenna_code,
	input  logic [1:0]        frame_hypothesis,
	input  logic [1:0]        frame_index,
	output logic              done,
	output logic              crc_ok,
	output logic [BW_W-1:0]   bandwidth_code,
	output logic              phich_duration,
	output logic [1:0]        phich_resource,
	output logic [SFN_W-1:0]  frame_number,
	output logic [1:0]        antenna_ports
);

	logic              valid_s1;
	logic [INFO_W-1:0] info_s1;
	logic [CRC_W-1:0]  crc_s1;
	logic [1:0]        ant_s1;
	logic [1:0]        hyp_s1;
	logic [1:0]        fidx_s1;

	logic              valid_s2;
	logic              crc_ok_s2;
	mib_fields_t       fields_s2;
	logic [1:0]        ant_s2;

	logic              crc_ok_c;
	mib_fields_t       fields_c;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			info_s1 <= info_bits;
			crc_s1 <= crc_bits;
			ant_s1 <= antenna_code;
			hyp_s1 <= frame_hypothesis;
			fidx_s1 <= frame_index;
		end
	end

	pmcd_crc_check u_crc_check (
		.info_bits    (info_s1),
		.crc_bits     (crc_s1),
		.antenna_code (ant_s1),
		.crc_ok       (crc_ok_c)
	);

	pmcd_mib_fields u_mib_fields (
		.info_bits        (info_s1),
		.frame_hypothesis (hyp_s1),
		.frame_index      (fidx_s1),
		.fields           (fields_c)
	);

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			crc_ok_s2 <= crc_ok_c;
			fields_s2 <= fields_c;
			ant_s2 <= ant_s1;
		end
	end

	assign done = valid_s2;
	assign crc_ok = crc_ok_s2;
	assign bandwidth_code = fields_s2.bandwidth_code;
	assign phich_duration = fields_s2.phich_duration;
	assign phich_resource = fields_s2.phich_resource;
	assign frame_number = fields_s2.frame_number;
	assign antenna_ports = ant_s2;

	a_accept_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> ##1 done)
		else $error("accepted word did not produce a result");

	a_no_spurious_done: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(valid_s1))
		else $error("result reported without a word in flight");

	a_unsup_fails: assert property (@(posedge clk) disable iff (!arst_n)
		done && antenna_ports == ANT_UNSUP |-> !crc_ok)
		else $error("unsupported antenna code passed the CRC check");

	a_bw_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> bandwidth_code <= BW_UNKNOWN)
		else $error("bandwidth code out of range");

endmodule

// ===== bench/pmcd_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PBCH MIB checker
// Predicts the CRC verdict and decoded fields of every broadcast word taken
// by the block, and compares each reported result against the oldest one.
// ----------------------------------------------------------------------------
package pmcd_bench_pkg;
	import pmcd_pkg::*;

	typedef struct packed {
		logic        crc_ok;
		mib_fields_t fields;
		logic [1:0]  antenna_ports;
	} mib_result_t;

	function automatic logic [CRC_W-1:0] crc16_over_info(input logic [INFO_W-1:0] info);
		logic [CRC_W-1:0] crc;
		logic fb;
		crc = '0;
		for (int i = INFO_W - 1; i >= 0; i--) begin
			fb = crc[CRC_W-1] ^ info[i];
			crc = {crc[CRC_W-2:0], 1'b0};
			if (fb) begin
				crc = crc ^ CRC_POLY;
			end
		end
		return crc;
	endfunction

	function automatic logic [CRC_W-1:0] crc_mask_for(input ant_code_t ant);
		case (ant)
			ANT_TWO: begin
				return MASK_TWO;
			end
			ANT_FOUR: begin
				return MASK_FOUR;
			end
			default: begin
				return MASK_ONE;
			end
		endcase
	endfunction

endpackage

module pmcd_checker
	import pmcd_pkg::*;
	import pmcd_bench_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              busy,
	input  logic [INFO_W-1:0] info_bits,
	input  logic [CRC_W-1:0]  crc_bits,
	input  logic [1:0]        antenna_code,
	input  logic [1:0]        frame_hypothesis,
	input  logic [1:0]        frame_index,
	input  logic              done,
	input  logic              crc_ok,
	input  logic [BW_W-1:0]   bandwidth_code,
	input  logic              phich_duration,
	input  logic [1:0]        phich_resource,
	input  logic [SFN_W-1:0]  frame_number,
	input  logic [1:0]        antenna_ports,
	output int                errors,
	output int                pending
);

	mib_result_t expected_mibs[$];

	function automatic mib_result_t decode_mib(input logic [INFO_W-1:0] info,
			input logic [CRC_W-1:0] crc_rx, input ant_code_t ant,
			input logic [1:0] hyp, input logic [1:0] fidx);
		mib_result_t r;
		logic [SFN_W-1:0] sfn;
		r.crc_ok = (ant != ANT_UNSUP) &&
			((crc_rx ^ crc_mask_for(ant)) == crc16_over_info(info));
		r.fields.bandwidth_code = info[23:21];
		if (r.fields.bandwidth_code > BW_MAX) begin
			r.fields.bandwidth_code = BW_UNKNOWN;
		end
		r.fields.phich_duration = info[20];
		r.fields.phich_resource = info[19:18];
		sfn = {info[17:10], 2'b00};
		sfn = sfn + SFN_W'(hyp) - SFN_W'(fidx);
		r.fields.frame_number = sfn;
		r.antenna_ports = ant;
		return r;
	endfunction

	task automatic compare_field(input string name, input int exp_val, input int act_val);
		if (exp_val != act_val) begin
			errors++;
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_val,
				act_val);
		end
	endtask

	initial begin
		errors = 0;
		pending = 0;
	end

	always @(posedge clk) begin
		mib_result_t exp_r;
		if (arst_n) begin
			if (done) begin
				if (expected_mibs.size() == 0) begin
					errors++;
					$display("%0t: result reported with no word outstanding", $time);
				end else begin
					exp_r = expected_mibs.pop_front();
					compare_field("crc_ok", exp_r.crc_ok, crc_ok);
					compare_field("bandwidth_code", exp_r.fields.bandwidth_code,
						bandwidth_code);
					compare_field("phich_duration", exp_r.fields.phich_duration,
						phich_duration);
					compare_field("phich_resource", exp_r.fields.phich_resource,
						phich_resource);
					compare_field("frame_number", exp_r.fields.frame_number, frame_number);
					compare_field("antenna_ports", exp_r.antenna_ports, antenna_ports);
				end
			end
			if (start && !busy) begin
				expected_mibs.push_back(decode_mib(info_bits, crc_bits,
					ant_code_t'(antenna_code), frame_hypothesis, frame_index));
			end
			pending = expected_mibs.size();
		end
	end

endmodule

// ===== bench/tb_pbch_mib_crc_check_decode_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PBCH MIB CRC check and decode testbench
// Feeds directed and random broadcast words, most with a correctly masked
// CRC, under several sender idle rates, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb_pbch_mib_crc_check_decode_top;
	import pmcd_pkg::*;
	import pmcd_bench_pkg::*;

	localparam int RANDOM_WORDS = 1500;
	localparam int CYCLE_LIMIT = 200000;

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	logic [INFO_W-1:0] info_bits;
	logic [CRC_W-1:0]  crc_bits;
	logic [1:0]        antenna_code;
	logic [1:0]        frame_hypothesis;
	logic [1:0]        frame_index;
	logic              done;
	logic              crc_ok;
	logic [BW_W-1:0]   bandwidth_code;
	logic              phich_duration;
	logic [1:0]        phich_resource;
	logic [SFN_W-1:0]  frame_number;
	logic [1:0]        antenna_ports;
	int                errors;
	int                pending;
	int                idle_pct;
	int                cycles;

	pbch_mib_crc_check_decode_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.info_bits(info_bits),
		.crc_bits(crc_bits),
		.antenna_code(antenna_code),
		.frame_hypothesis(frame_hypothesis),
		.frame_index(frame_index),
		.done(done),
		.crc_ok(crc_ok),
		.bandwidth_code(bandwidth_code),
		.phich_duration(phich_duration),
		.phich_resource(phich_resource),
		.frame_number(frame_number),
		.antenna_ports(antenna_ports)
	);

	pmcd_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.info_bits(info_bits),
		.crc_bits(crc_bits),
		.antenna_code(antenna_code),
		.frame_hypothesis(frame_hypothesis),
		.frame_index(frame_index),
		.done(done),
		.crc_ok(crc_ok),
		.bandwidth_code(bandwidth_code),
		.phich_duration(phich_duration),
		.phich_resource(phich_resource),
		.frame_number(frame_number),
		.antenna_ports(antenna_ports),
		.errors(errors),
		.pending(pending)
	);

	initial begin
		clk = 1'b0;
	end

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	task automatic send_word(input logic [INFO_W-1:0] info, input logic [CRC_W-1:0] crc,
			input ant_code_t ant, input logic [1:0] hyp, input logic [1:0] fidx);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		info_bits <= info;
		crc_bits <= crc;
		antenna_code <= ant;
		frame_hypothesis <= hyp;
		frame_index <= fidx;
		@(posedge clk);
		while (busy) begin
			@(posedge clk);
		end
	endtask

	function automatic logic [CRC_W-1:0] masked_crc(input logic [INFO_W-1:0] info,
			input ant_code_t ant);
		return crc16_over_info(info) ^ crc_mask_for(ant);
	endfunction

	task automatic send_random_word();
		logic [INFO_W-1:0] info;
		logic [CRC_W-1:0] crc;
		ant_code_t ant;
		int kind;
		info = INFO_W'($urandom);
		ant = ant_code_t'($urandom_range(3));
		kind = $urandom_range(9);
		crc = masked_crc(info, ant);
		if (kind >= 8) begin
			crc = CRC_W'($urandom);
		end else if (kind >= 6) begin
			crc = crc ^ (CRC_W'(1) << $urandom_range(CRC_W - 1));
		end
		send_word(info, crc, ant, 2'($urandom_range(3)), 2'($urandom_range(3)));
	endtask

	initial begin
		int phase_idle[4];
		cycles = 0;
		idle_pct = 0;
		phase_idle = '{0, 68, 0, 31};
		arst_n = 1'b0;
		start = 1'b0;
		info_bits = '0;
		crc_bits = '0;
		antenna_code = ANT_ONE;
		frame_hypothesis = '0;
		frame_index = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Extremes of the words, each antenna hypothesis with a good CRC, and the
		// unsupported code carrying a CRC that would pass unmasked.
		send_word(24'h000000, masked_crc(24'h000000, ANT_ONE), ANT_ONE, 2'd0, 2'd0);
		send_word(24'hFFFFFF, masked_crc(24'hFFFFFF, ANT_ONE), ANT_ONE, 2'd3, 2'd3);
		send_word(24'hFFFFFF, masked_crc(24'hFFFFFF, ANT_TWO), ANT_TWO, 2'd3, 2'd0);
		send_word(24'h5A5A5A, masked_crc(24'h5A5A5A, ANT_FOUR), ANT_FOUR, 2'd1, 2'd2);
		send_word(24'h123456, masked_crc(24'h123456, ANT_ONE), ANT_UNSUP, 2'd2, 2'd1);
		send_word(24'h000000, 16'h0000, ANT_UNSUP, 2'd0, 2'd0);
		send_word(24'h000000, 16'hFFFF, ANT_TWO, 2'd0, 2'd0);
		send_word(24'h000000, 16'h5555, ANT_FOUR, 2'd0, 2'd0);
		// Wrong CRCs: the fields are still decoded.
		send_word(24'hABCDEF, masked_crc(24'hABCDEF, ANT_TWO) ^ 16'h8000, ANT_TWO,
			2'd1, 2'd1);
		send_word(24'h3C0FF0, 16'hFFFF, ANT_ONE, 2'd2, 2'd3);
		// Frame number underflow and the largest frame number.
		send_word(24'h000000, 16'h1234, ANT_ONE, 2'd0, 2'd3);
		send_word(24'h03FC00, masked_crc(24'h03FC00, ANT_FOUR), ANT_FOUR, 2'd3, 2'd0);
		// Every bandwidth code, including the two unknown ones.
		for (int bw = 0; bw < 8; bw++) begin
			send_word({3'(bw), 21'h0A5C3F}, masked_crc({3'(bw), 21'h0A5C3F}, ANT_ONE),
				ANT_ONE, 2'(bw), 2'(bw >> 1));
		end

		for (int phase = 0; phase < 4; phase++) begin
			idle_pct = phase_idle[phase];
			for (int n = 0; n < RANDOM_WORDS / 4; n++) begin
				send_random_word();
			end
		end
		start <= 1'b0;

		while (pending != 0) begin
			@(posedge clk);
		end
		repeat (8) @(posedge clk);
		if (errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
